### hw/rtl/ifbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the index field byte decoder.
// Used by ifbd_step, ifbd_out_buf and index_field_byte_decoder_unit; no dependencies.
package ifbd_pkg;

    localparam int KindW  = 3;
    localparam int ByteW  = 8;
    localparam int ValueW = 64;
    localparam int CountW = 4;
    localparam int NeedW  = 2;

    // Field kinds, as carried on the kind lines of both channels
    localparam logic [KindW-1:0] KIND_VINT32  = 3'd0;
    localparam logic [KindW-1:0] KIND_VLONG64 = 3'd1;
    localparam logic [KindW-1:0] KIND_INT16   = 3'd2;
    localparam logic [KindW-1:0] KIND_INT32   = 3'd3;
    localparam logic [KindW-1:0] KIND_INT64   = 3'd4;
    localparam logic [KindW-1:0] KIND_CHAR    = 3'd5;

    localparam logic [CountW-1:0] VINT32_MAX_BYTES  = 4'd5;
    localparam logic [CountW-1:0] VLONG64_MAX_BYTES = 4'd10;
    localparam logic [CountW-1:0] INT16_BYTES       = 4'd2;
    localparam logic [CountW-1:0] INT32_BYTES       = 4'd4;
    localparam logic [CountW-1:0] INT64_BYTES       = 4'd8;

    localparam int OutDataW = 72;   // value and bytes_used, padded to whole bytes
    localparam int OutUserW = 4;    // value_kind and overlong_error

    typedef struct packed {
        logic [ValueW-1:0] accumulator;
        logic [CountW-1:0] byte_index;
        logic [KindW-1:0]  active_kind;
        logic [NeedW-1:0]  char_bytes_needed;
        logic              in_value;
    } t_state;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [KindW-1:0]  value_kind;
        logic [CountW-1:0] bytes_used;
        logic              overlong_error;
    } t_result;

endpackage

### hw/rtl/index_field_byte_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the index field byte decoder: state registers, decode step, output buffer.
// Depends on ifbd_pkg, ifbd_step and ifbd_out_buf.

// Takes one byte per cycle on the slave stream; tuser on the first byte of a value
// selects its kind (vint32, vlong64, big-endian int16/32/64, modified UTF-8 char) and is
// ignored on later bytes, while kinds 6 and 7 on a first byte drop that byte. One item
// is decoded in the cycle it is accepted; a finished value is registered before it
// reaches the master stream. A two-entry output register keeps bytes flowing at one per
// cycle while a single result is stalled, and only a second stalled result holds off
// the input. Varints stop at 5 or 10 bytes with the overlong flag set.
module index_field_byte_decoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] data_byte
    input  logic [2:0]                     i_s_tuser,   // [2:0] req_type
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ifbd_pkg::OutDataW-1:0]  o_m_tdata,   // [63:0] value, [67:64] bytes_used
    output logic [ifbd_pkg::OutUserW-1:0]  o_m_tuser    // [2:0] value_kind, [3] overlong_error
);

    ifbd_pkg::t_state  r_state;
    ifbd_pkg::t_state  n_state;
    ifbd_pkg::t_result step_res;
    ifbd_pkg::t_result out_res;
    logic              step_valid;
    logic              s_accept;

    assign s_accept = i_s_tvalid && o_s_tready;

    ifbd_step u_step (
        .i_state     (r_state),
        .i_req_type  (i_s_tuser),
        .i_data_byte (i_s_tdata),
        .o_next      (n_state),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    ifbd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_accept && step_valid),
        .i_res       (step_res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_res       (out_res),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = {4'd0, out_res.bytes_used, out_res.value};
    assign o_m_tuser = {out_res.overlong_error, out_res.value_kind};

    ap_unknown_kind_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_state.in_value && i_s_tuser > ifbd_pkg::KIND_CHAR)
        |=> !r_state.in_value)
        else $error("unknown kind started a value");

    ap_bytes_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (out_res.bytes_used >= 4'd1 && out_res.bytes_used <= 4'd10))
        else $error("bytes_used out of range");

    ap_err_only_varint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && out_res.overlong_error) |->
        (out_res.value_kind == ifbd_pkg::KIND_VINT32 ||
         out_res.value_kind == ifbd_pkg::KIND_VLONG64))
        else $error("overlong flag on a non-varint");

    ap_vint32_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.in_value && r_state.active_kind == ifbd_pkg::KIND_VINT32)
        |-> (r_state.byte_index < ifbd_pkg::VINT32_MAX_BYTES))
        else $error("vint32 ran past its byte limit");

endmodule

### hw/rtl/ifbd_step.sv
`timescale 1ns / 1ps
// Per-byte decode step: next decoder state and the finished value, if any.
// Depends on ifbd_pkg.
module ifbd_step (
    input  ifbd_pkg::t_state             i_state,
    input  logic [ifbd_pkg::KindW-1:0]   i_req_type,
    input  logic [ifbd_pkg::ByteW-1:0]   i_data_byte,
    output ifbd_pkg::t_state             o_next,
    output logic                         o_res_valid,
    output ifbd_pkg::t_result            o_res
);

    logic [ifbd_pkg::KindW-1:0]   kind_eff;
    logic [ifbd_pkg::ValueW-1:0]  acc0;
    logic [ifbd_pkg::ValueW-1:0]  acc1;
    logic [ifbd_pkg::ValueW-1:0]  masked;
    logic [ifbd_pkg::CountW-1:0]  idx0;
    logic [ifbd_pkg::CountW-1:0]  idx1;
    logic [ifbd_pkg::CountW-1:0]  idx_m1;
    logic [ifbd_pkg::CountW-1:0]  limit;
    logic [6:0]                   shamt;
    logic [ifbd_pkg::NeedW-1:0]   need0;
    logic [ifbd_pkg::NeedW-1:0]   need1;
    logic                         known;
    logic                         done;
    logic                         err;

    always_comb begin
        kind_eff = i_state.in_value ? i_state.active_kind : i_req_type;
        acc0     = i_state.in_value ? i_state.accumulator : '0;
        idx0     = i_state.in_value ? i_state.byte_index : '0;
        need0    = i_state.in_value ? i_state.char_bytes_needed : '0;
        known    = i_state.in_value || (i_req_type <= ifbd_pkg::KIND_CHAR);
        idx1     = idx0 + 4'd1;
        idx_m1   = idx0;
        // 7 * (byte number - 1), as shift minus one
        shamt    = ({3'b000, idx_m1} << 3) - {3'b000, idx_m1};
        acc1     = acc0;
        need1    = need0;
        done     = 1'b0;
        err      = 1'b0;
        limit    = ifbd_pkg::VLONG64_MAX_BYTES;

        case (kind_eff)
            ifbd_pkg::KIND_VINT32, ifbd_pkg::KIND_VLONG64: begin
                limit = (kind_eff == ifbd_pkg::KIND_VINT32) ?
                        ifbd_pkg::VINT32_MAX_BYTES : ifbd_pkg::VLONG64_MAX_BYTES;
                if (shamt < 7'd64) begin
                    acc1 = acc0 | ({57'd0, i_data_byte[6:0]} << shamt[5:0]);
                end
                if (!i_data_byte[7]) begin
                    done = 1'b1;
                end else if (idx1 >= limit) begin
                    done = 1'b1;
                    err  = 1'b1;
                end
            end
            ifbd_pkg::KIND_INT16, ifbd_pkg::KIND_INT32, ifbd_pkg::KIND_INT64: begin
                acc1 = {acc0[ifbd_pkg::ValueW-9:0], i_data_byte};
                if (kind_eff == ifbd_pkg::KIND_INT16) begin
                    done = (idx1 >= ifbd_pkg::INT16_BYTES);
                end else if (kind_eff == ifbd_pkg::KIND_INT32) begin
                    done = (idx1 >= ifbd_pkg::INT32_BYTES);
                end else begin
                    done = (idx1 >= ifbd_pkg::INT64_BYTES);
                end
            end
            ifbd_pkg::KIND_CHAR: begin
                if (idx1 == 4'd1) begin
                    if (!i_data_byte[7]) begin
                        acc1 = {57'd0, i_data_byte[6:0]};
                        done = 1'b1;
                    end else if (i_data_byte[7:5] != 3'b111) begin
                        acc1  = {59'd0, i_data_byte[4:0]};
                        need1 = 2'd1;
                    end else begin
                        acc1  = {60'd0, i_data_byte[3:0]};
                        need1 = 2'd2;
                    end
                end else begin
                    acc1 = {acc0[ifbd_pkg::ValueW-7:0], i_data_byte[5:0]};
                    if (need0 != 2'd0) begin
                        need1 = need0 - 2'd1;
                    end
                    done = (need1 == 2'd0);
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase

        case (kind_eff)
            ifbd_pkg::KIND_VINT32, ifbd_pkg::KIND_INT32: masked = {32'd0, acc1[31:0]};
            ifbd_pkg::KIND_INT16, ifbd_pkg::KIND_CHAR:   masked = {48'd0, acc1[15:0]};
            default:                                     masked = acc1;
        endcase

        o_next.accumulator       = acc1;
        o_next.byte_index        = idx1;
        o_next.active_kind       = kind_eff;
        o_next.char_bytes_needed = need1;
        o_next.in_value          = known && !done;

        o_res_valid          = known && done;
        o_res.value          = masked;
        o_res.value_kind     = kind_eff;
        o_res.bytes_used     = idx1;
        o_res.overlong_error = err;
    end

endmodule

### hw/rtl/ifbd_out_buf.sv
`timescale 1ns / 1ps
// Two-entry output register with skid stage for finished values.
// Depends on ifbd_pkg.
module ifbd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ifbd_pkg::t_result  i_res,
    output logic               o_ready,
    output logic               o_valid,
    output ifbd_pkg::t_result  o_res,
    input  logic               i_pop_ready
);

    logic              r_main_valid;
    logic              r_skid_valid;
    ifbd_pkg::t_result r_main;
    ifbd_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
                r_main       <= i_res;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
            r_main       <= i_res;
        end else if (i_push) begin
            // main is stalled: park the item in the skid stage
            r_skid_valid <= 1'b1;
            r_skid       <= i_res;
        end
    end

    ap_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage full while main register empty");

endmodule

### tb/ifbd_value_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the index field byte decoder: watches both streams, predicts each value
// from the accepted bytes and compares every result field. Depends on ifbd_pkg.
module ifbd_value_checker
    import ifbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] data_byte
    input  logic [2:0]           i_s_tuser,   // [2:0] req_type
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OutDataW-1:0]  i_m_tdata,   // [63:0] value, [67:64] bytes_used
    input  logic [OutUserW-1:0]  i_m_tuser,   // [2:0] value_kind, [3] overlong_error
    output int                   o_mismatch_count,
    output int                   o_outstanding
);

    logic [ValueW-1:0] run_acc;
    logic [CountW-1:0] run_count;
    logic [KindW-1:0]  run_kind;
    logic [NeedW-1:0]  chars_owed;
    logic              run_open;

    t_result decoded_values[$];
    int      mismatch_total = 0;

    assign o_mismatch_count = mismatch_total;

    // Advance the decode by one byte; queue the finished value when it completes.
    task automatic decode_byte(input logic [KindW-1:0] req, input logic [ByteW-1:0] b);
        t_result           done_value;
        logic              done;
        logic              err;
        logic [CountW-1:0] limit;
        logic [CountW-1:0] len;
        int                shift;
        done = 1'b0;
        err  = 1'b0;
        if (!run_open) begin
            // drop a first byte that names no kind
            if (req > KIND_CHAR) return;
            run_kind   = req;
            run_acc    = '0;
            run_count  = '0;
            chars_owed = '0;
        end
        run_count = run_count + 1'b1;

        case (run_kind)
            KIND_VINT32, KIND_VLONG64: begin
                limit = (run_kind == KIND_VINT32) ? VINT32_MAX_BYTES : VLONG64_MAX_BYTES;
                shift = 7 * (int'(run_count) - 1);
                if (shift < 64) run_acc = run_acc | ({57'd0, b[6:0]} << shift);
                if (!b[7]) begin
                    done = 1'b1;
                end else if (run_count >= limit) begin
                    done = 1'b1;
                    err  = 1'b1;
                end
            end
            KIND_INT16, KIND_INT32, KIND_INT64: begin
                len = (run_kind == KIND_INT16) ? INT16_BYTES :
                      (run_kind == KIND_INT32) ? INT32_BYTES : INT64_BYTES;
                run_acc = {run_acc[ValueW-9:0], b};
                if (run_count >= len) done = 1'b1;
            end
            default: begin
                if (run_count == 4'd1) begin
                    if (!b[7]) begin
                        run_acc = {57'd0, b[6:0]};
                        done    = 1'b1;
                    end else if (b[7:5] != 3'b111) begin
                        run_acc    = {59'd0, b[4:0]};
                        chars_owed = 2'd1;
                    end else begin
                        run_acc    = {60'd0, b[3:0]};
                        chars_owed = 2'd2;
                    end
                end else begin
                    // continuation: top two bits are not checked
                    run_acc = {run_acc[ValueW-7:0], b[5:0]};
                    if (chars_owed > 0) chars_owed = chars_owed - 1'b1;
                    if (chars_owed == 0) done = 1'b1;
                end
            end
        endcase

        if (!done) begin
            run_open = 1'b1;
            return;
        end

        done_value.value = run_acc;
        if (run_kind == KIND_VINT32 || run_kind == KIND_INT32)
            done_value.value = {32'd0, run_acc[31:0]};
        else if (run_kind == KIND_INT16 || run_kind == KIND_CHAR)
            done_value.value = {48'd0, run_acc[15:0]};
        done_value.value_kind     = run_kind;
        done_value.bytes_used     = run_count;
        done_value.overlong_error = err;
        decoded_values.push_back(done_value);

        run_open   = 1'b0;
        run_acc    = '0;
        run_count  = '0;
        chars_owed = '0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            run_acc    = '0;
            run_count  = '0;
            run_kind   = '0;
            chars_owed = '0;
            run_open   = 1'b0;
            decoded_values.delete();
        end else begin
            // compare before predicting: a byte taken this edge cannot be out yet
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_values.size() == 0) begin
                    $error("unexpected result: value %h kind %0d", i_m_tdata[63:0],
                           i_m_tuser[2:0]);
                    mismatch_total++;
                end else begin
                    want = decoded_values.pop_front();
                    if (i_m_tdata[63:0] !== want.value) begin
                        $error("value: expected %h, got %h", want.value, i_m_tdata[63:0]);
                        mismatch_total++;
                    end
                    if (i_m_tuser[2:0] !== want.value_kind) begin
                        $error("value_kind: expected %0d, got %0d", want.value_kind,
                               i_m_tuser[2:0]);
                        mismatch_total++;
                    end
                    if (i_m_tdata[67:64] !== want.bytes_used) begin
                        $error("bytes_used: expected %0d, got %0d", want.bytes_used,
                               i_m_tdata[67:64]);
                        mismatch_total++;
                    end
                    if (i_m_tuser[3] !== want.overlong_error) begin
                        $error("overlong_error: expected %0b, got %0b", want.overlong_error,
                               i_m_tuser[3]);
                        mismatch_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) decode_byte(i_s_tuser, i_s_tdata);
        end
        o_outstanding <= decoded_values.size();
    end

endmodule

### tb/index_field_byte_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Top of the decoder bench: clock, reset, byte stream and result back-pressure, verdict.
// Depends on ifbd_pkg, ifbd_value_checker and index_field_byte_decoder_unit.
module index_field_byte_decoder_unit_tb;
    import ifbd_pkg::*;

    localparam logic [KindW-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KindW-1:0] KIND_SPARE_HI = 3'd7;
    localparam int STREAM_BYTES  = 1750;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIRECTED_LEN  = 28;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;   // [7:0] data_byte
    logic [2:0]          i_s_tuser;   // [2:0] req_type
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OutDataW-1:0] o_m_tdata;   // [63:0] value, [67:64] bytes_used
    logic [OutUserW-1:0] o_m_tuser;   // [2:0] value_kind, [3] overlong_error

    int   mismatch_count;
    int   outstanding;
    logic steady;
    int   quiet_cycles;

    // {req_type, data_byte}; bytes after the first of a value may carry unrelated kinds
    localparam logic [10:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        {KIND_SPARE_HI, 8'hAB},
        // vint32 of five all-ones bytes: wide and overlong at once
        {KIND_VINT32, 8'hFF}, {KIND_CHAR, 8'hFF}, {KIND_INT64, 8'hFF},
        {KIND_SPARE_HI, 8'hFF}, {KIND_VINT32, 8'hFF},
        // vlong64 of ten bytes, the last one clear of continuation
        {KIND_VLONG64, 8'hFF}, {KIND_VINT32, 8'hFF}, {KIND_VINT32, 8'hFF},
        {KIND_VINT32, 8'hFF}, {KIND_VINT32, 8'hFF}, {KIND_VINT32, 8'hFF},
        {KIND_VINT32, 8'hFF}, {KIND_VINT32, 8'hFF}, {KIND_VINT32, 8'hFF},
        {KIND_INT16, 8'h7F},
        {KIND_INT16, 8'hFF}, {KIND_SPARE_LO, 8'h00},
        {KIND_INT32, 8'h80}, {KIND_INT32, 8'h00}, {KIND_INT32, 8'h00}, {KIND_INT32, 8'h01},
        // chars: one byte, a 10xxxxxx lead, a 111xxxxx lead
        {KIND_CHAR, 8'h7F},
        {KIND_CHAR, 8'h80}, {KIND_CHAR, 8'h3F},
        {KIND_CHAR, 8'hFF}, {KIND_CHAR, 8'h00}, {KIND_CHAR, 8'hFF}
    };

    index_field_byte_decoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ifbd_value_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one byte, idling first at random, and hold it until taken.
    task automatic send_byte(input logic [2:0] req, input logic [7:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int               sent;
        int               n;
        int               limit;
        int               lead_class;
        logic [KindW-1:0] kind;
        logic [7:0]       b;
        logic             overlong;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b0;
        steady       = 1'b0;
        sent         = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i][10:8], DIRECTED_BYTES[i][7:0]);

        while (sent < STREAM_BYTES) begin
            // hold both sides free of idling through one long stretch
            steady = (sent >= 700 && sent < 1000);
            if ($urandom_range(0, 99) < 5) begin
                send_byte(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                          8'($urandom_range(0, 255)));
                sent += 1;
                continue;
            end
            kind = 3'($urandom_range(KIND_VINT32, KIND_CHAR));
            case (kind)
                KIND_VINT32, KIND_VLONG64: begin
                    limit    = int'((kind == KIND_VINT32) ? VINT32_MAX_BYTES :
                                                            VLONG64_MAX_BYTES);
                    overlong = ($urandom_range(0, 9) == 0);
                    n        = overlong ? limit : int'($urandom_range(1, limit));
                    for (int i = 0; i < n; i++) begin
                        b    = 8'($urandom_range(0, 255));
                        b[7] = overlong || (i != n - 1);
                        send_byte((i == 0) ? kind : 3'($urandom_range(0, 7)), b);
                    end
                end
                KIND_INT16, KIND_INT32, KIND_INT64: begin
                    n = int'((kind == KIND_INT16) ? INT16_BYTES :
                             (kind == KIND_INT32) ? INT32_BYTES : INT64_BYTES);
                    for (int i = 0; i < n; i++)
                        send_byte((i == 0) ? kind : 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)));
                end
                default: begin
                    lead_class = int'($urandom_range(0, 2));
                    n = lead_class + 1;
                    case (lead_class)
                        0:       b = 8'($urandom_range(8'h00, 8'h7F));
                        1:       b = 8'($urandom_range(8'h80, 8'hDF));
                        default: b = 8'($urandom_range(8'hE0, 8'hFF));
                    endcase
                    send_byte(kind, b);
                    for (int i = 1; i < n; i++)
                        send_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
            endcase
            sent += n;
        end

        steady = 1'b0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ifbd_pkg.sv
hw/rtl/ifbd_step.sv
hw/rtl/ifbd_out_buf.sv
hw/rtl/index_field_byte_decoder_unit.sv
tb/ifbd_value_checker.sv
tb/index_field_byte_decoder_unit_tb.sv
